/* design/rses_pkg.sv */
package rses_pkg;

	localparam int FractionBitsDef = 24;
	localparam int LineCountDef    = 11;
	localparam int TableSize       = 16;
	localparam int EnergyW         = 15;
	localparam int ModeW           = 2;

	localparam logic [EnergyW-1:0] MeTk    = 15'd5110;
	localparam logic [EnergyW-1:0] TmaxTk  = 15'd22800;
	localparam logic [EnergyW-1:0] CsTk    = 15'd6620;
	localparam logic [EnergyW-1:0] CoTk    = 15'd12500;

	// beta envelope: floor(3/2 * shape(Tp)), Tp = 9120, pp = 13280; fits in 56 bits
	localparam logic [63:0] NmaxBeta = 64'd53047684131840000;

	typedef enum logic [ModeW-1:0] {
		MODE_RA = 2'd0,
		MODE_SR = 2'd1,
		MODE_CS = 2'd2,
		MODE_CO = 2'd3
	} mode_t;

	typedef struct packed {
		logic [23:0] uniform_a;
		logic [23:0] uniform_b;
	} in_beat_t;

	typedef struct packed {
		logic [14:0] energy_tenth_kev;
		logic        accepted;
		logic        is_electron;
	} out_beat_t;

	function automatic logic [14:0] line_energy(input logic [3:0] i);
		logic [14:0] e;
		case (i)
			4'd0: e = 15'd2420;
			4'd1: e = 15'd2952;
			4'd2: e = 15'd3519;
			4'd3: e = 15'd6093;
			4'd4: e = 15'd7684;
			4'd5: e = 15'd9341;
			4'd6: e = 15'd11203;
			4'd7: e = 15'd12381;
			4'd8: e = 15'd13780;
			4'd9: e = 15'd17645;
			4'd10: e = 15'd22041;
			default: e = 15'd0;
		endcase
		return e;
	endfunction

	function automatic logic [10:0] line_weight(input logic [3:0] i);
		logic [10:0] w;
		case (i)
			4'd0: w = 11'd74;
			4'd1: w = 11'd193;
			4'd2: w = 11'd376;
			4'd3: w = 11'd461;
			4'd4: w = 11'd49;
			4'd5: w = 11'd31;
			4'd6: w = 11'd151;
			4'd7: w = 11'd58;
			4'd8: w = 11'd40;
			4'd9: w = 11'd154;
			4'd10: w = 11'd49;
			default: w = 11'd0;
		endcase
		return w;
	endfunction

endpackage

/* design/rses_isqrt.sv */
// Pipelined integer square root of a 32-bit radicand, one result bit a stage.
// Extra payload rides along in the sideband.
module rses_isqrt #(
	parameter int SideW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [31:0]      x,
	input  logic [SideW-1:0] side_in,
	output logic             out_vld,
	output logic [15:0]      root,
	output logic [SideW-1:0] side_out
);
	localparam int Steps = 16;

	logic [31:0]      rem_s [Steps+1];
	logic [15:0]      res_s [Steps+1];
	logic [SideW-1:0] sd_s  [Steps+1];
	logic             v_s   [Steps+1];

	assign rem_s[0] = x;
	assign res_s[0] = '0;
	assign sd_s[0]  = side_in;
	assign v_s[0]   = in_vld;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [33:0] trial;
		logic [33:0] rem_w;
		logic        take;
		// try setting root bit (15-k)
		assign trial = (34'(res_s[k]) << (Steps - k)) |
			(34'd1 << (2 * (Steps - 1 - k)));
		assign rem_w = {2'b0, rem_s[k]};
		assign take  = rem_w >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - trial[31:0] : rem_s[k];
				res_s[k+1] <= take ? (res_s[k] | (16'd1 << (Steps - 1 - k))) : res_s[k];
				sd_s[k+1]  <= sd_s[k];
			end
		end
	end

	assign out_vld  = v_s[Steps];
	assign root     = res_s[Steps];
	assign side_out = sd_s[Steps];
endmodule

/* design/rses_line_pick.sv */
// Inverse-CDF line pick: compare a*total against every cumulative weight,
// register the hit vector, then priority-select the energy.
module rses_line_pick #(
	parameter int FractionBits = rses_pkg::FractionBitsDef,
	parameter int LineCount    = rses_pkg::LineCountDef
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [FractionBits-1:0] a,
	output logic [14:0]             energy
);
	localparam int N = (LineCount < rses_pkg::TableSize) ? LineCount : rses_pkg::TableSize;
	localparam int CumW = 16;
	localparam int ProdW = FractionBits + CumW;

	logic [CumW-1:0] cum [N];
	logic [CumW-1:0] total;
	logic [N-1:0]    hit_s1;
	logic [ProdW-1:0] prod;

	// prefix sums of constant weights
	always_comb begin
		logic [CumW-1:0] acc;
		acc = '0;
		for (int i = 0; i < N; i++) begin
			acc = acc + CumW'(rses_pkg::line_weight(4'(i)));
			cum[i] = acc;
		end
		total = acc;
	end

	assign prod = ProdW'(a) * ProdW'(total);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				hit_s1[i] <= prod <= ({{FractionBits{1'b0}}, cum[i]} << FractionBits);
			end
		end
	end

	// first hit wins, last line as fallback
	always_comb begin
		energy = rses_pkg::line_energy(4'(N - 1));
		for (int i = N - 1; i >= 0; i--) begin
			if (hit_s1[i]) begin
				energy = rses_pkg::line_energy(4'(i));
			end
		end
	end
endmodule

/* design/radiation_source_energy_sampler.sv */
// Throughput: one beat per cycle; stalls freeze the whole pipeline.
// Stages: trial energy, shape terms, 16 square-root stages, two product
// stages, envelope compare, output register.
// Reset: arst_n clears all valid bits and sets mode_q to radium lines.
module radiation_source_energy_sampler #(
	parameter int FractionBits = rses_pkg::FractionBitsDef,
	parameter int LineCount    = rses_pkg::LineCountDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  rses_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rses_pkg::out_beat_t out_data
);
	typedef struct packed {
		rses_pkg::mode_t mode;
		logic [14:0]     t;
		logic [23:0]     b;
		logic [14:0]     ra;
	} side_t;
	localparam int SideW = $bits(side_t);
	localparam logic [27:0] NmaxLo = rses_pkg::NmaxBeta[27:0];
	localparam logic [27:0] NmaxHi = rses_pkg::NmaxBeta[55:28];

	rses_pkg::mode_t mode_q;
	logic            en;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rses_pkg::MODE_RA;
		end else if (cfg_valid) begin
			mode_q <= rses_pkg::mode_t'(cfg_data);
		end
	end

	// mask fractions to the configured width
	logic [FractionBits-1:0] a_m, b_m;
	assign a_m = FractionBits'(in_data.uniform_a);
	assign b_m = FractionBits'(in_data.uniform_b);

	// stage 1: trial energy and radium pick compare
	logic        v_s1;
	logic [14:0] t_s1;
	logic [23:0] b_s1;
	rses_pkg::mode_t mode_s1;
	logic [14:0] ra_e;
	logic [FractionBits+14:0] tprod;
	assign tprod = (FractionBits+15)'(rses_pkg::TmaxTk) * (FractionBits+15)'(a_m);

	rses_line_pick #(.FractionBits(FractionBits), .LineCount(LineCount)) u_pick (
		.clk(clk), .en(en), .a(a_m), .energy(ra_e)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= tprod[FractionBits+14:FractionBits];
			b_s1    <= 24'(b_m);
			mode_s1 <= mode_q;
		end
	end

	// stage 2: radicand t*(t+2me)
	logic        v_s2;
	logic [31:0] x_s2;
	side_t       sd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= 32'(t_s1) * (32'(t_s1) + 32'(2 * rses_pkg::MeTk));
			sd_s2 <= '{mode: mode_s1, t: t_s1, b: b_s1, ra: ra_e};
		end
	end

	// square root pipeline
	logic        v_r;
	logic [15:0] p_r;
	side_t       sd_r;
	logic [SideW-1:0] sd_r_raw;
	rses_isqrt #(.SideW(SideW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s2), .x(x_s2),
		.side_in(sd_s2), .out_vld(v_r), .root(p_r), .side_out(sd_r_raw)
	);
	assign sd_r = side_t'(sd_r_raw);

	// stage 3: p*(t+me) and d*d
	logic        v_s3;
	logic [31:0] pt_s3, dd_s3;
	side_t       sd_s3;
	logic [14:0] d_w;
	assign d_w = rses_pkg::TmaxTk - sd_r.t;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_r;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pt_s3 <= 32'(p_r) * 32'(17'(sd_r.t) + 17'(rses_pkg::MeTk));
			dd_s3 <= 32'(d_w) * 32'(d_w);
			sd_s3 <= sd_r;
		end
	end

	// stage 4: shape N (64-bit, exact) and b*Nmax partial products
	logic        v_s4;
	logic [63:0] n_s4;
	logic [51:0] bl_s4, bh_s4;
	side_t       sd_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s4  <= 64'(pt_s3) * 64'(dd_s3);
			bl_s4 <= 52'(sd_s3.b) * 52'(NmaxLo);
			bh_s4 <= 52'(sd_s3.b) * 52'(NmaxHi);
			sd_s4 <= sd_s3;
		end
	end

	// stage 5: b*Nmax against N<<FractionBits, 128-bit exact
	logic        v_s5;
	logic        ok_s5;
	side_t       sd_s5;
	logic [127:0] lhs, rhs;
	assign lhs = (128'(bh_s4) << 28) + 128'(bl_s4);
	assign rhs = 128'(n_s4) << FractionBits;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5 <= lhs <= rhs;
			sd_s5 <= sd_s4;
		end
	end

	// output register: select per mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (sd_s5.mode)
				rses_pkg::MODE_RA: out_data <= '{energy_tenth_kev: sd_s5.ra,
					accepted: 1'b1, is_electron: 1'b0};
				rses_pkg::MODE_SR: out_data <= '{energy_tenth_kev: sd_s5.t,
					accepted: ok_s5, is_electron: 1'b1};
				rses_pkg::MODE_CS: out_data <= '{energy_tenth_kev: rses_pkg::CsTk,
					accepted: 1'b1, is_electron: 1'b0};
				default:           out_data <= '{energy_tenth_kev: rses_pkg::CoTk,
					accepted: 1'b1, is_electron: 1'b0};
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rej_only_beta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |-> out_data.is_electron)
		else $error("rejected beat outside beta mode");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output beat changed");
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.energy_tenth_kev <= rses_pkg::TmaxTk)
		else $error("energy out of range");
`endif
endmodule
